[rtl/core/tks_pkg.sv]
package tks_pkg;

  // build-time defaults
  localparam int MAX_KEEP_DEF = 16;
  localparam int K_W          = 5;
  localparam int COST_W       = 32;
  localparam int PAYLOAD_W    = 64;
  localparam int DATA_W       = 32;
  localparam int ADDR_W       = 3;
  localparam logic [K_W-1:0] K_USED_RESET = K_W'(16);

  // register index as decoded from paddr
  typedef enum logic {
    REG_K_USED = 1'b0
  } reg_index_t;

  // input item
  typedef struct packed {
    logic signed [COST_W-1:0] cost;
    logic [PAYLOAD_W-1:0]     payload;
    logic                     last_in;
  } in_item_t;

  // result item
  typedef struct packed {
    logic signed [COST_W-1:0] best_cost;
    logic [PAYLOAD_W-1:0]     best_payload;
    logic                     last_out;
  } out_item_t;

  // one stored entry
  typedef struct packed {
    logic signed [COST_W-1:0] cost;
    logic [PAYLOAD_W-1:0]     payload;
  } entry_t;

  // per-cycle command shared by all cells
  typedef struct packed {
    logic insert;
    logic drain;
  } cell_ctrl_t;

endpackage

[rtl/core/tks_cell.sv]
module tks_cell (
  input  logic                clk,
  input  tks_pkg::cell_ctrl_t ctrl,
  input  logic                beyond,
  input  logic                left_take,
  input  tks_pkg::entry_t     left_entry,
  input  tks_pkg::entry_t     right_entry,
  input  tks_pkg::entry_t     new_entry,
  output tks_pkg::entry_t     entry,
  output logic                take
);
  import tks_pkg::*;

  // new item belongs at or before this cell
  assign take = beyond || (entry.cost > new_entry.cost);

  // insert shifts right from the insertion point, drain shifts left
  always_ff @(posedge clk) begin
    if (ctrl.insert && take) begin
      entry <= left_take ? left_entry : new_entry;
    end else if (ctrl.drain) begin
      entry <= right_entry;
    end
  end

endmodule

[rtl/core/top_k_smallest_selector.sv]
// Top-k smallest-cost selector.
// Items arrive on the command channel: an item is taken at a clock edge with
// start high and busy low. Each item is compared against every held entry at
// once in a sorted chain of cells and inserted in the same cycle, so a run of
// items without last_in is taken at one item per cycle.
// When an item with last_in is taken, busy rises on the next cycle and the
// held entries are shifted out of the head cell, one per cycle, in ascending
// cost order (equal costs in arrival order). Each result sits on result for
// one cycle with result_valid high; the final one carries last_out. The
// receiver cannot stall. While the entries drain, the block takes no new
// item; one result leaves per entry held, 1 up to the effective k below.
// k_used is written over the APB-style port at byte address 0; the user must
// do so only while idle, as the block itself does not enforce it.
// Zero acts as 1 and values above MAX_KEEP act as MAX_KEEP (the effective k).
// Reset empties the store and sets k_used to 16; no clearing pass is needed.
module top_k_smallest_selector #(
  parameter int MAX_KEEP = tks_pkg::MAX_KEEP_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  tks_pkg::in_item_t            item,
  output logic                         result_valid,
  output tks_pkg::out_item_t           result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tks_pkg::ADDR_W-1:0]   paddr,
  input  logic [tks_pkg::DATA_W-1:0]   pwdata,
  output logic [tks_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);
  import tks_pkg::*;

  localparam int CW = $clog2(MAX_KEEP + 1);
  localparam int EW = (CW > K_W) ? CW + 1 : K_W + 1;

  logic [K_W-1:0] k_used;
  logic [CW-1:0]  count;
  logic [CW-1:0]  remaining;
  logic           cfg_write;
  reg_index_t     reg_sel;
  logic [CW-1:0]  eff_k;
  logic [CW-1:0]  cnt_eff;
  logic [CW-1:0]  count_after;
  logic           accept;
  logic           enter;
  logic           has_room;
  cell_ctrl_t     ctrl;
  entry_t         new_entry;
  entry_t         entries [MAX_KEEP];
  logic [MAX_KEEP-1:0] take;
  logic [MAX_KEEP-1:0] tail;

  // configuration port
  assign pready    = 1'b1;
  assign reg_sel   = reg_index_t'(paddr[ADDR_W-1]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      k_used <= K_USED_RESET;
    end else if (cfg_write && reg_sel == REG_K_USED) begin
      k_used <= pwdata[K_W-1:0];
    end
  end

  always_comb begin
    case (reg_sel)
      REG_K_USED: prdata = DATA_W'(k_used);
      default:    prdata = '0;
    endcase
  end

  // effective k and held count clipped to it
  always_comb begin
    if (k_used == '0) begin
      eff_k = CW'(1);
    end else if (EW'(k_used) > EW'(MAX_KEEP)) begin
      eff_k = CW'(MAX_KEEP);
    end else begin
      eff_k = CW'(k_used);
    end
    cnt_eff = (count > eff_k) ? eff_k : count;
  end

  // admission decision
  assign accept    = start && !busy;
  assign has_room  = cnt_eff < eff_k;
  assign enter     = has_room || (|(take & tail));
  assign count_after = has_room ? cnt_eff + CW'(1) : cnt_eff;

  assign new_entry.cost    = item.cost;
  assign new_entry.payload = item.payload;
  assign ctrl.insert = accept && enter;
  assign ctrl.drain  = busy;

  // cell chain
  for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
    logic   beyond;
    logic   left_take;
    entry_t left_entry;
    entry_t right_entry;

    assign beyond  = CW'(i) >= cnt_eff;
    assign tail[i] = CW'(i + 1) == cnt_eff;

    if (i == 0) begin : g_head
      assign left_take  = 1'b0;
      assign left_entry = new_entry;
    end else begin : g_body
      assign left_take  = take[i-1];
      assign left_entry = entries[i-1];
    end

    if (i == MAX_KEEP - 1) begin : g_end
      assign right_entry = entries[i];
    end else begin : g_mid
      assign right_entry = entries[i+1];
    end

    tks_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .beyond      (beyond),
      .left_take   (left_take),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .new_entry   (new_entry),
      .entry       (entries[i]),
      .take        (take[i])
    );
  end

  // fill count and drain sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      busy      <= 1'b0;
      remaining <= '0;
    end else if (busy) begin
      remaining <= remaining - CW'(1);
      if (remaining == CW'(1)) begin
        busy <= 1'b0;
      end
    end else if (accept) begin
      if (item.last_in) begin
        busy      <= 1'b1;
        remaining <= enter ? count_after : cnt_eff;
        count     <= '0;
      end else begin
        count <= enter ? count_after : cnt_eff;
      end
    end
  end

  // results leave from the head cell
  assign result_valid        = busy;
  assign result.best_cost    = entries[0].cost;
  assign result.best_payload = entries[0].payload;
  assign result.last_out     = remaining == CW'(1);

  // checks
  a_drain_ends : assert property (@(posedge clk) disable iff (rst)
    busy && remaining == CW'(1) |=> !busy)
    else $error("drain did not end after its final transfer");

  a_last_starts_drain : assert property (@(posedge clk) disable iff (rst)
    accept && item.last_in |=> result_valid)
    else $error("no result after a last item");

  a_ascending : assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last_out |=> result_valid &&
      result.best_cost >= $past(result.best_cost))
    else $error("results not in ascending cost order");

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_KEEP) && remaining <= CW'(MAX_KEEP))
    else $error("held count exceeds store depth");

endmodule

[bench/top_k_smallest_selector_tb.sv]
module top_k_smallest_selector_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tks_pkg::*;

  localparam int KEEP_MAX       = MAX_KEEP_DEF;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int TAIL_CYCLES    = 2 * KEEP_MAX + 8;

  typedef enum logic {
    ROW_ITEM,
    ROW_SET_K
  } row_kind_t;

  typedef struct {
    row_kind_t        kind;
    logic [K_W-1:0]   k;
    in_item_t         it;
    bit               typed;
    out_item_t        want;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  in_item_t           item = '0;
  logic               result_valid;
  out_item_t          result;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [ADDR_W-1:0]  paddr = '0;
  logic [DATA_W-1:0]  pwdata = '0;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  // shadow of the selector state
  logic signed [COST_W-1:0] kept_cost [KEEP_MAX];
  logic [PAYLOAD_W-1:0]     kept_payload [KEEP_MAX];
  int                       kept_n = 0;
  logic [K_W-1:0]           k_shadow = K_USED_RESET;

  out_item_t  due_results[$];
  stim_row_t  directed[$];
  int         errors = 0;
  int         idle_cycles = 0;
  int         burst_left = 0;

  top_k_smallest_selector dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .result_valid (result_valid),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #5 clk = ~clk;

  // number of entries kept for a given register value
  function automatic int keep_limit(logic [K_W-1:0] k);
    if (k == 0) begin
      return 1;
    end else if (k > KEEP_MAX) begin
      return KEEP_MAX;
    end
    return int'(k);
  endfunction

  // sorted insert of one item, emit the ascending run on last
  function automatic void rank_item(input in_item_t it, output out_item_t run[$]);
    int        lim;
    int        pos;
    bit        enter;
    out_item_t r;
    run = {};
    lim = keep_limit(k_shadow);
    if (kept_n > lim) kept_n = lim;
    enter = 1'b0;
    if (kept_n < lim) begin
      enter = 1'b1;
    end else if (kept_n > 0 && $signed(it.cost) < kept_cost[kept_n-1]) begin
      kept_n--;
      enter = 1'b1;
    end
    if (enter) begin
      pos = kept_n;
      // equal costs stay behind earlier arrivals
      while (pos > 0 && kept_cost[pos-1] > $signed(it.cost)) begin
        kept_cost[pos]    = kept_cost[pos-1];
        kept_payload[pos] = kept_payload[pos-1];
        pos--;
      end
      kept_cost[pos]    = $signed(it.cost);
      kept_payload[pos] = it.payload;
      kept_n++;
    end
    if (it.last_in) begin
      for (int i = 0; i < kept_n; i++) begin
        r.best_cost    = kept_cost[i];
        r.best_payload = kept_payload[i];
        r.last_out     = (i == kept_n - 1);
        run.push_back(r);
      end
      kept_n = 0;
    end
  endfunction

  task automatic report_mismatch(string what, logic [PAYLOAD_W-1:0] got,
                                 logic [PAYLOAD_W-1:0] want);
    $display("%t %s: got %h, want %h", $realtime, what, got, want);
    errors++;
  endtask

  // one input transfer, sent in bursts with random gaps
  task automatic send_item(in_item_t it, bit typed, out_item_t want);
    int        gap;
    out_item_t run[$];
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        start <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk);
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy);
    rank_item(it, run);
    if (typed) begin
      due_results.push_back(want);
    end else begin
      foreach (run[i]) due_results.push_back(run[i]);
    end
  endtask

  // register write while idle: setup then access phase
  task automatic set_k_used(logic [K_W-1:0] k);
    @(negedge clk);
    start <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(4 * int'(REG_K_USED));
    pwdata  <= DATA_W'(k);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    k_shadow = k;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    burst_left = 0;
  endtask

  function automatic void add_item(logic signed [COST_W-1:0] cost,
                                   logic [PAYLOAD_W-1:0] payload, bit last, bit typed);
    stim_row_t row;
    row.kind              = ROW_ITEM;
    row.k                 = '0;
    row.it.cost           = cost;
    row.it.payload        = payload;
    row.it.last_in        = last;
    row.typed             = typed;
    // a typed row always leaves just this item in the store
    row.want.best_cost    = cost;
    row.want.best_payload = payload;
    row.want.last_out     = 1'b1;
    directed.push_back(row);
  endfunction

  function automatic void add_k(logic [K_W-1:0] k);
    stim_row_t row;
    row.kind  = ROW_SET_K;
    row.k     = k;
    row.it    = '0;
    row.typed = 1'b0;
    row.want  = '0;
    directed.push_back(row);
  endfunction

  // result check against the oldest expectation
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (!rst && result_valid) begin
      if (due_results.size() == 0) begin
        report_mismatch("result with nothing due", result.best_payload, '0);
      end else begin
        want = due_results.pop_front();
        if (result.best_cost !== want.best_cost)
          report_mismatch("best_cost", PAYLOAD_W'(result.best_cost),
                          PAYLOAD_W'(want.best_cost));
        if (result.best_payload !== want.best_payload)
          report_mismatch("best_payload", result.best_payload, want.best_payload);
        if (result.last_out !== want.last_out)
          report_mismatch("last_out", PAYLOAD_W'(result.last_out),
                          PAYLOAD_W'(want.last_out));
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("top_k_smallest_selector: mismatch");
      $finish;
    end else if (rst || (start && !busy) || result_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int        k_plan[8];
    int        keep_n;
    int        set_left;
    in_item_t  it;
    k_plan = '{31, 17, 0, 1, 16, -1, -1, -1};

    // directed rows: extremes, ties, eviction, k edge values
    add_item(32'sh7FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1);
    add_item(32'sh8000_0000, 64'h0, 1'b1, 1'b1);
    add_item(32'sh0005_0000, 64'h1, 1'b0, 1'b0);
    add_item(32'sh0005_0000, 64'h2, 1'b0, 1'b0);
    add_item(-32'sh0003_0000, 64'h3, 1'b0, 1'b0);
    add_item(32'sh0005_0000, 64'h4, 1'b1, 1'b0);
    add_item(32'sh0000_0000, 64'h5555_5555_5555_5555, 1'b0, 1'b0);
    add_item(-32'sh0000_0001, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 1'b0);
    add_k(5'd1);
    add_item(32'sh000A_0000, 64'hA, 1'b0, 1'b0);
    add_item(32'sh000A_0000, 64'hB, 1'b0, 1'b0);
    add_item(32'sh0009_0000, 64'hC, 1'b1, 1'b1);
    add_k(5'd0);
    add_item(32'sh0003_0000, 64'hD, 1'b0, 1'b0);
    add_item(32'sh0001_0000, 64'hE, 1'b1, 1'b1);
    add_k(5'd2);
    add_item(32'sh0004_0000, 64'h10, 1'b0, 1'b0);
    add_item(32'sh0002_0000, 64'h11, 1'b0, 1'b0);
    add_item(32'sh0003_0000, 64'h12, 1'b1, 1'b0);
    // k lowered while entries are held
    add_k(5'd3);
    add_item(32'sh0007_0000, 64'h20, 1'b0, 1'b0);
    add_item(32'sh0005_0000, 64'h21, 1'b0, 1'b0);
    add_item(32'sh0006_0000, 64'h22, 1'b0, 1'b0);
    add_k(5'd1);
    add_item(32'sh0008_0000, 64'h23, 1'b1, 1'b0);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_SET_K) begin
        set_k_used(directed[i].k);
      end else begin
        send_item(directed[i].it, directed[i].typed, directed[i].want);
      end
    end

    // random phases, each under its own k setting
    foreach (k_plan[p]) begin
      set_k_used((k_plan[p] < 0) ? K_W'($urandom_range(0, 31)) : K_W'(k_plan[p]));
      keep_n   = keep_limit(k_shadow);
      set_left = 0;
      repeat (25) begin
        if (set_left == 0) begin
          set_left = ($urandom_range(0, 4) == 0) ? $urandom_range(keep_n, keep_n + 10)
                                                 : $urandom_range(1, keep_n + 2);
        end
        set_left--;
        case ($urandom_range(0, 5))
          0, 1: it.cost = $urandom();
          2, 3: it.cost = COST_W'($urandom_range(0, 7)) << 16;
          4:    it.cost = COST_W'($urandom_range(0, 15)) - COST_W'(8);
          default: begin
            case ($urandom_range(0, 2))
              0:       it.cost = 32'sh8000_0000;
              1:       it.cost = 32'sh7FFF_FFFF;
              default: it.cost = 32'sh0000_0000;
            endcase
          end
        endcase
        it.payload = {$urandom(), $urandom()};
        it.last_in = (set_left == 0);
        // occasional broken set boundary
        if ($urandom_range(0, 19) == 0) it.last_in = ~it.last_in;
        send_item(it, 1'b0, '0);
      end
    end

    @(negedge clk);
    start <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("top_k_smallest_selector: match");
    end else begin
      $display("top_k_smallest_selector: mismatch");
    end
    $finish;
  end

endmodule

[top_k_smallest_selector.f]
rtl/core/tks_pkg.sv
rtl/core/tks_cell.sv
rtl/core/top_k_smallest_selector.sv
bench/top_k_smallest_selector_tb.sv
